/* design/sar_pkg.sv */
// Package for the summed-area table rectangle-mean block.
// Holds the shared codes, the controller states and the command and status structs.
// No dependencies.
package sar_pkg;

  localparam int unsigned DEF_MAX_COLS   = 1024;
  localparam int unsigned DEF_MAX_ROWS   = 256;
  localparam int unsigned DEF_NUM_IMAGES = 3;

  localparam int unsigned DIV_NW = 40;
  localparam int unsigned DIV_DW = 20;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_ZERO  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_COLS  = 2'd0,
    CFG_SHIFT = 2'd1,
    CFG_SCALE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_DISP,
    FSM_LD_PRE,
    FSM_LD_ROW,
    FSM_LD_COL,
    FSM_LD_CELL,
    FSM_Q_R0,
    FSM_Q_R1,
    FSM_Q_R2,
    FSM_Q_R3,
    FSM_Q_SUM,
    FSM_Q_ZCHK,
    FSM_Q_DIV,
    FSM_OUT
  } fsm_e;

  typedef struct packed {
    logic      take;
    logic      start;
    logic      ld_pre;
    logic      ld_row;
    logic      ld_col;
    logic      ld_cell;
    logic      q_area;
    logic      rd_en;
    logic [1:0] rd_sel;
    acc_op_e   acc_op;
    logic      div_start;
    logic      out_load;
    status_e   out_status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic img_ok;
    logic drop;
    logic q_bad;
    logic area_zero;
    logic div_done;
    logic out_busy;
  } dp_sts_t;

endpackage

/* design/summed_area_table_rect_mean.sv */
// Summed-area tables with rectangle-mean queries. A load sample passes through multiply,
// row sum, column buffer update, rounding and table write, in that order.
// A query does four table reads, then runs the one-bit-per-cycle 40-bit mean divider; a
// zero area skips the divider, an out-of-range query skips both, and a result stall holds any.
// Reset is asynchronous, active low; it restores the register defaults and clears
// row counts and sums. The column buffer needs no clearing pass: a fill count masks it.
module summed_area_table_rect_mean #(
  parameter int unsigned MAX_COLS   = sar_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS   = sar_pkg::DEF_MAX_ROWS,
  parameter int unsigned NUM_IMAGES = sar_pkg::DEF_NUM_IMAGES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // sample_value, row_a, row_b, col_a, col_b, zero padding.
  input  logic [63:0] s_axis_tdata_i,
  // command, image_sel.
  input  logic [3:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // rect_sum, rect_mean.
  output logic [71:0] m_axis_tdata_o,
  // status.
  output logic [1:0]  m_axis_tuser_o
);

  sar_pkg::dp_cmd_t cmd;
  sar_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sar_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .NUM_IMAGES (NUM_IMAGES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_user_i   (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_user_o  (m_axis_tuser_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

/* design/sar_div.sv */
// Restoring divider for the rectangle mean, one quotient bit per cycle.
// Unsigned magnitudes only; the caller applies the sign. Uses sar_pkg.
module sar_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [sar_pkg::DIV_NW-1:0]     dividend_i,
  input  logic [sar_pkg::DIV_DW-1:0]     divisor_i,
  output logic                           done_o,
  output logic [sar_pkg::DIV_NW-1:0]     quotient_o
);

  localparam int unsigned CW = $clog2(sar_pkg::DIV_NW + 1);

  logic                          run_q, run_d;
  logic                          done_q, done_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [sar_pkg::DIV_NW-1:0]    num_q, num_d;
  logic [sar_pkg::DIV_DW-1:0]    den_q, den_d;
  logic [sar_pkg::DIV_DW-1:0]    rem_q, rem_d;
  logic [sar_pkg::DIV_DW:0]      rem_sh;
  logic                          qbit;

  always_comb begin
    rem_sh = {rem_q, num_q[sar_pkg::DIV_NW-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CW'(sar_pkg::DIV_NW);
      num_d = dividend_i;
      den_d = divisor_i;
      rem_d = '0;
    end else if (run_q) begin
      num_d = {num_q[sar_pkg::DIV_NW-2:0], qbit};
      rem_d = qbit ? sar_pkg::DIV_DW'(rem_sh - {1'b0, den_q})
                   : sar_pkg::DIV_DW'(rem_sh);
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

/* design/sar_dp.sv */
// Datapath: configuration registers, column buffer, table memory, query sum and output register.
// Driven by sar_ctrl through sar_pkg command and status structs; instantiates sar_div.
module sar_dp #(
  parameter int unsigned MAX_COLS   = sar_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS   = sar_pkg::DEF_MAX_ROWS,
  parameter int unsigned NUM_IMAGES = sar_pkg::DEF_NUM_IMAGES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [23:0]       cfg_data_i,
  input  logic [3:0]        in_user_i,
  input  logic [63:0]       in_data_i,
  input  sar_pkg::dp_cmd_t  cmd_i,
  output sar_pkg::dp_sts_t  sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        out_user_o,
  output logic [71:0]       out_data_o
);

  localparam int unsigned CIW   = $clog2(MAX_COLS);
  localparam int unsigned LCW   = $clog2(MAX_COLS + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned DEPTH = NUM_IMAGES * MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [10:0]          cols_q;
  logic [23:0]          shift_q, scale_q;

  logic [1:0]           cmd_q, img_q;
  logic [23:0]          samp_q;
  logic [7:0]           ra_q, rb_q;
  logic [9:0]           ca_q, cb_q;

  logic [RW-1:0]        rows_q [NUM_IMAGES];
  logic [RW-1:0]        sel_rows;
  logic [LCW-1:0]       load_col_q, fill_q, act, nxt_col;
  logic [63:0]          rs_q, cs_q, col_rd_q, col_v, cs_new;
  logic signed [49:0]   prod_q;
  logic signed [24:0]   diff;
  logic [31:0]          cell_rd_q, acc_q, cell_val;
  logic signed [19:0]   area_q;
  logic signed [10:0]   dc;
  logic signed [8:0]    dr;
  logic                 img_ok, neg_q;
  logic [63:0]          mag, rnd;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [39:0]          dvd, dvd_mag, quot;
  logic [19:0]          dvs_mag;
  logic                 div_done;

  logic                 ov_q;
  logic [1:0]           ost_q;
  logic [31:0]          osum_q;
  logic [39:0]          omean_q;

  logic [31:0]          cell_mem [DEPTH];
  logic [63:0]          col_mem  [MAX_COLS];

  function automatic logic [AW-1:0] cell_addr(input logic [1:0] img,
                                               input logic [31:0] row,
                                               input logic [31:0] col);
    logic [31:0] a;
    a = (32'(img) * MAX_ROWS + row) * MAX_COLS + col;
    return AW'(a);
  endfunction

  always_comb begin
    if (cols_q < 11'd2) act = LCW'(2);
    else if (32'(cols_q) > MAX_COLS) act = LCW'(MAX_COLS);
    else act = LCW'(cols_q);
  end

  always_comb begin
    sel_rows = '0;
    for (int i = 0; i < NUM_IMAGES; i++) begin
      if (32'(img_q) == i) sel_rows = rows_q[i];
    end
  end

  assign img_ok  = 32'(img_q) < NUM_IMAGES;
  assign nxt_col = load_col_q + LCW'(1);
  assign diff    = $signed({samp_q[23], samp_q}) - $signed({shift_q[23], shift_q});
  assign col_v   = (32'(load_col_q) < 32'(fill_q)) ? col_rd_q : 64'd0;
  assign cs_new  = col_v + rs_q;
  assign mag     = cs_q[63] ? (~cs_q + 64'd1) : cs_q;
  assign rnd     = mag + 64'h8_0000;
  assign cell_val = cs_q[63] ? (~rnd[51:20] + 32'd1) : rnd[51:20];
  assign dc      = $signed({1'b0, cb_q}) - $signed({1'b0, ca_q});
  assign dr      = $signed({1'b0, rb_q}) - $signed({1'b0, ra_q});
  assign dvd     = {acc_q, 8'd0};
  assign dvd_mag = acc_q[31] ? (~dvd + 40'd1) : dvd;
  assign dvs_mag = area_q[19] ? 20'(-area_q) : 20'(area_q);
  assign wr_addr = cell_addr(img_q, 32'(sel_rows), 32'(load_col_q));

  always_comb begin
    unique case (cmd_i.rd_sel)
      2'd0:    rd_addr = cell_addr(img_q, 32'(rb_q), 32'(cb_q));
      2'd1:    rd_addr = cell_addr(img_q, 32'(ra_q), 32'(ca_q));
      2'd2:    rd_addr = cell_addr(img_q, 32'(rb_q), 32'(ca_q));
      default: rd_addr = cell_addr(img_q, 32'(ra_q), 32'(cb_q));
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= 11'd800;
      shift_q    <= 24'd0;
      scale_q    <= 24'd256;
      load_col_q <= '0;
      fill_q     <= '0;
      rs_q       <= '0;
      ov_q       <= 1'b0;
      for (int i = 0; i < NUM_IMAGES; i++) rows_q[i] <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sar_pkg::CFG_COLS:  cols_q  <= cfg_data_i[10:0];
          sar_pkg::CFG_SHIFT: shift_q <= cfg_data_i;
          sar_pkg::CFG_SCALE: scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        load_col_q <= '0;
        fill_q     <= '0;
        rs_q       <= '0;
        for (int i = 0; i < NUM_IMAGES; i++) begin
          if (32'(img_q) == i) rows_q[i] <= '0;
        end
      end
      if (cmd_i.ld_pre && (load_col_q >= act)) begin
        load_col_q <= '0;
        rs_q       <= '0;
        for (int i = 0; i < NUM_IMAGES; i++) begin
          if (32'(img_q) == i && 32'(rows_q[i]) < MAX_ROWS) rows_q[i] <= rows_q[i] + RW'(1);
        end
      end
      if (cmd_i.ld_row) rs_q <= rs_q + 64'(prod_q);
      if (cmd_i.ld_col && !(32'(load_col_q) < 32'(fill_q))) fill_q <= nxt_col;
      if (cmd_i.ld_cell) begin
        if (nxt_col >= act) begin
          load_col_q <= '0;
          rs_q       <= '0;
          for (int i = 0; i < NUM_IMAGES; i++) begin
            if (32'(img_q) == i && 32'(rows_q[i]) < MAX_ROWS) rows_q[i] <= rows_q[i] + RW'(1);
          end
        end else begin
          load_col_q <= nxt_col;
        end
      end
      if (cmd_i.out_load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cmd_q  <= in_user_i[1:0];
      img_q  <= in_user_i[3:2];
      samp_q <= in_data_i[23:0];
      ra_q   <= in_data_i[31:24];
      rb_q   <= in_data_i[39:32];
      ca_q   <= in_data_i[49:40];
      cb_q   <= in_data_i[59:50];
    end
    if (cmd_i.ld_pre) prod_q <= diff * $signed({1'b0, scale_q});
    if (cmd_i.ld_row) col_rd_q <= col_mem[load_col_q[CIW-1:0]];
    if (cmd_i.ld_col) begin
      col_mem[load_col_q[CIW-1:0]] <= cs_new;
      cs_q <= cs_new;
    end
    if (cmd_i.ld_cell) cell_mem[wr_addr] <= cell_val;
    if (cmd_i.rd_en) cell_rd_q <= cell_mem[rd_addr];
    case (cmd_i.acc_op)
      sar_pkg::ACC_LOAD: acc_q <= cell_rd_q;
      sar_pkg::ACC_ADD:  acc_q <= acc_q + cell_rd_q;
      sar_pkg::ACC_SUB:  acc_q <= acc_q - cell_rd_q;
      default: ;
    endcase
    if (cmd_i.q_area) area_q <= dc * dr;
    if (cmd_i.div_start) neg_q <= acc_q[31] ^ area_q[19];
    if (cmd_i.out_load) begin
      ost_q <= cmd_i.out_status;
      unique case (cmd_i.out_status)
        sar_pkg::STS_OK: begin
          osum_q  <= acc_q;
          omean_q <= neg_q ? (~quot + 40'd1) : quot;
        end
        sar_pkg::STS_ZERO: begin
          osum_q  <= acc_q;
          omean_q <= '0;
        end
        default: begin
          osum_q  <= '0;
          omean_q <= '0;
        end
      endcase
    end
  end

  sar_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_mag),
    .divisor_i  (dvs_mag),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_comb begin
    sts_o.cmd       = sar_pkg::cmd_e'(cmd_q);
    sts_o.img_ok    = img_ok;
    sts_o.drop      = 32'(sel_rows) >= MAX_ROWS;
    sts_o.q_bad     = !img_ok || 32'(ra_q) >= 32'(sel_rows) ||
                      32'(rb_q) >= 32'(sel_rows) || 32'(ca_q) >= 32'(act) ||
                      32'(cb_q) >= 32'(act);
    sts_o.area_zero = area_q == 20'sd0;
    sts_o.div_done  = div_done;
    sts_o.out_busy  = ov_q && !out_ready_i;
  end

  assign out_valid_o = ov_q;
  assign out_user_o  = ost_q;
  assign out_data_o  = {omean_q, osum_q};

endmodule

/* design/sar_ctrl.sv */
// Controller state machine sequencing start, load and query items.
// Drives the sar_dp command struct and reads its status struct from sar_pkg.
module sar_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sar_pkg::dp_sts_t  sts_i,
  output sar_pkg::dp_cmd_t  cmd_o
);

  sar_pkg::fsm_e    state_q, state_d;
  sar_pkg::status_e ost_q, ost_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sar_pkg::FSM_IDLE;
      ost_q   <= sar_pkg::STS_OK;
    end else begin
      state_q <= state_d;
      ost_q   <= ost_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ost_d      = ost_q;
    cmd_o      = '0;
    cmd_o.acc_op     = sar_pkg::ACC_NONE;
    cmd_o.out_status = ost_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      sar_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i) state_d = sar_pkg::FSM_DISP;
      end
      sar_pkg::FSM_DISP: begin
        state_d = sar_pkg::FSM_IDLE;
        unique case (sts_i.cmd)
          sar_pkg::CMD_START: cmd_o.start = sts_i.img_ok;
          sar_pkg::CMD_LOAD: begin
            if (sts_i.img_ok) state_d = sar_pkg::FSM_LD_PRE;
          end
          sar_pkg::CMD_QUERY: begin
            if (sts_i.q_bad) begin
              ost_d   = sar_pkg::STS_RANGE;
              state_d = sar_pkg::FSM_OUT;
            end else begin
              state_d = sar_pkg::FSM_Q_R0;
            end
          end
          default: ;
        endcase
      end
      sar_pkg::FSM_LD_PRE: begin
        cmd_o.ld_pre = 1'b1;
        state_d      = sar_pkg::FSM_LD_ROW;
      end
      sar_pkg::FSM_LD_ROW: begin
        if (sts_i.drop) begin
          state_d = sar_pkg::FSM_IDLE;
        end else begin
          cmd_o.ld_row = 1'b1;
          state_d      = sar_pkg::FSM_LD_COL;
        end
      end
      sar_pkg::FSM_LD_COL: begin
        cmd_o.ld_col = 1'b1;
        state_d      = sar_pkg::FSM_LD_CELL;
      end
      sar_pkg::FSM_LD_CELL: begin
        cmd_o.ld_cell = 1'b1;
        state_d       = sar_pkg::FSM_IDLE;
      end
      sar_pkg::FSM_Q_R0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = 2'd0;
        cmd_o.q_area = 1'b1;
        state_d      = sar_pkg::FSM_Q_R1;
      end
      sar_pkg::FSM_Q_R1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = 2'd1;
        cmd_o.acc_op = sar_pkg::ACC_LOAD;
        state_d      = sar_pkg::FSM_Q_R2;
      end
      sar_pkg::FSM_Q_R2: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = 2'd2;
        cmd_o.acc_op = sar_pkg::ACC_ADD;
        state_d      = sar_pkg::FSM_Q_R3;
      end
      sar_pkg::FSM_Q_R3: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = 2'd3;
        cmd_o.acc_op = sar_pkg::ACC_SUB;
        state_d      = sar_pkg::FSM_Q_SUM;
      end
      sar_pkg::FSM_Q_SUM: begin
        cmd_o.acc_op = sar_pkg::ACC_SUB;
        state_d      = sar_pkg::FSM_Q_ZCHK;
      end
      sar_pkg::FSM_Q_ZCHK: begin
        if (sts_i.area_zero) begin
          ost_d   = sar_pkg::STS_ZERO;
          state_d = sar_pkg::FSM_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = sar_pkg::FSM_Q_DIV;
        end
      end
      sar_pkg::FSM_Q_DIV: begin
        if (sts_i.div_done) begin
          ost_d   = sar_pkg::STS_OK;
          state_d = sar_pkg::FSM_OUT;
        end
      end
      sar_pkg::FSM_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = sar_pkg::FSM_IDLE;
        end
      end
      default: state_d = sar_pkg::FSM_IDLE;
    endcase
  end

endmodule

/* design/sar_chk.sv */
// Port-level checker for summed_area_table_rect_mean, attached by bind.
// Uses sar_pkg status codes.
module sar_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
    $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o != 2'd3)
    else $error("undefined status code");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == sar_pkg::STS_RANGE |-> m_axis_tdata_o == 72'd0)
    else $error("out-of-range result carries data");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == sar_pkg::STS_ZERO |-> m_axis_tdata_o[71:32] == 40'd0)
    else $error("zero-area result carries a mean");

endmodule

bind summed_area_table_rect_mean sar_chk u_sar_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* sim/summed_area_table_rect_mean_test.sv */
// Testbench for the summed-area table rectangle-mean block: it loads images and checks
// every query against an internal predictor of the tables, with random stalls on both sides.
// Depends on sar_pkg and summed_area_table_rect_mean.
`timescale 1ns / 1ps

module summed_area_table_rect_mean_test;

  localparam int unsigned NCOLS = 1024;
  localparam int unsigned NROWS = 256;
  localparam int unsigned NIMG = 3;
  localparam int unsigned WATCHDOG_CYCLES = 20000;
  localparam int unsigned SETTLE_CYCLES = 100;

  typedef struct {
    sar_pkg::status_e status;
    bit [31:0] rect_sum;
    bit [39:0] rect_mean;
  } rect_answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic [3:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  summed_area_table_rect_mean u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i), .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tuser_o(m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  bit [31:0] sat_cells [NIMG*NROWS*NCOLS];
  bit        cell_written [NIMG*NROWS*NCOLS];
  bit [63:0] col_acc [NCOLS];
  bit [63:0] row_acc;
  int unsigned load_col;
  int unsigned rows_done [NIMG];
  bit [10:0] cols_reg;
  bit [23:0] shift_reg;
  bit [23:0] scale_reg;

  rect_answer_t answers_pending [$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned answers_checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;

  function automatic int unsigned active_cols();
    if (cols_reg < 2) return 2;
    if (cols_reg > NCOLS) return NCOLS;
    return cols_reg;
  endfunction

  function automatic int unsigned cell_idx(int unsigned img, int unsigned row,
                                           int unsigned col);
    return (img * NROWS + row) * NCOLS + col;
  endfunction

  function automatic bit [31:0] round_cell(bit [63:0] v);
    bit [63:0] mag;
    bit [63:0] r;
    mag = v[63] ? -v : v;
    r = (mag + 64'd524288) >> 20;
    if (v[63]) r = -r;
    return r[31:0];
  endfunction

  function automatic void close_row(int unsigned img);
    if (rows_done[img] < NROWS) rows_done[img]++;
    load_col = 0;
    row_acc = '0;
  endfunction

  function automatic void accumulate_sample(int unsigned img, bit [23:0] smp);
    longint diff;
    int unsigned col;
    int unsigned idx;
    if (load_col >= active_cols()) close_row(img);
    if (rows_done[img] >= NROWS) return;
    diff = longint'($signed(smp)) - longint'($signed(shift_reg));
    row_acc += 64'(diff * longint'(scale_reg));
    col = load_col % NCOLS;
    col_acc[col] += row_acc;
    idx = cell_idx(img, rows_done[img], col);
    sat_cells[idx] = round_cell(col_acc[col]);
    cell_written[idx] = 1'b1;
    load_col++;
    if (load_col >= active_cols()) close_row(img);
  endfunction

  function automatic bit query_in_range(int unsigned img, int unsigned ra, int unsigned rb,
                                        int unsigned ca, int unsigned cb);
    if (img >= NIMG) return 1'b0;
    return ra < rows_done[img] && rb < rows_done[img] && ca < active_cols() &&
           cb < active_cols();
  endfunction

  function automatic void predict_word(sar_pkg::cmd_e cmd, bit [1:0] img, bit [23:0] smp,
                                       bit [7:0] ra, bit [7:0] rb, bit [9:0] ca, bit [9:0] cb);
    rect_answer_t ans;
    bit [31:0] u;
    longint area;
    case (cmd)
      sar_pkg::CMD_START: begin
        if (img < NIMG) begin
          rows_done[img] = 0;
          foreach (col_acc[i]) col_acc[i] = '0;
          row_acc = '0;
          load_col = 0;
        end
      end
      sar_pkg::CMD_LOAD: begin
        if (img < NIMG) accumulate_sample(img, smp);
      end
      sar_pkg::CMD_QUERY: begin
        ans.rect_sum = '0;
        ans.rect_mean = '0;
        if (!query_in_range(img, ra, rb, ca, cb)) begin
          ans.status = sar_pkg::STS_RANGE;
        end else begin
          u = sat_cells[cell_idx(img, rb, cb)] + sat_cells[cell_idx(img, ra, ca)]
            - sat_cells[cell_idx(img, rb, ca)] - sat_cells[cell_idx(img, ra, cb)];
          area = (longint'(cb) - longint'(ca)) * (longint'(rb) - longint'(ra));
          ans.rect_sum = u;
          if (area == 0) begin
            ans.status = sar_pkg::STS_ZERO;
          end else begin
            ans.status = sar_pkg::STS_OK;
            ans.rect_mean = 40'((longint'($signed(u)) * 256) / area);
          end
        end
        answers_pending.push_back(ans);
      end
      default: ;
    endcase
  endfunction

  // Result checking.
  always @(posedge clk_i) begin
    rect_answer_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (answers_pending.size() == 0) begin
        $error("unexpected result word: status %0d sum %0h", m_axis_tuser_o,
               m_axis_tdata_o[31:0]);
        errors++;
      end else begin
        want = answers_pending.pop_front();
        answers_checked++;
        if (m_axis_tuser_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tdata_o[31:0] !== want.rect_sum) begin
          $error("rect_sum: expected %0h, got %0h", want.rect_sum, m_axis_tdata_o[31:0]);
          errors++;
        end
        if (m_axis_tdata_o[71:32] !== want.rect_mean) begin
          $error("rect_mean: expected %0h, got %0h", want.rect_mean, m_axis_tdata_o[71:32]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog expired with %0d results outstanding", answers_pending.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(sar_pkg::cmd_e cmd, bit [1:0] img, bit [23:0] smp = '0,
                           bit [7:0] ra = '0, bit [7:0] rb = '0,
                           bit [9:0] ca = '0, bit [9:0] cb = '0);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'b0, cb, ca, rb, ra, smp};
    s_axis_tuser_i <= {img, cmd};
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    words_sent++;
    predict_word(cmd, img, smp, ra, rb, ca, cb);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (answers_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(sar_pkg::cfg_idx_e idx, bit [23:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    case (idx)
      sar_pkg::CFG_COLS:  cols_reg = value[10:0];
      sar_pkg::CFG_SHIFT: shift_reg = value;
      default:            scale_reg = value;
    endcase
  endtask

  function automatic bit [23:0] pick_sample();
    case ($urandom_range(9))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'h000000;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic load_rows(bit [1:0] img, int unsigned nrows);
    repeat (nrows * active_cols()) send_word(sar_pkg::CMD_LOAD, img, pick_sample());
  endtask

  // Picks corners that are out of range or read only written cells; falls back to an out-of-range image.
  task automatic send_query(bit [1:0] img);
    bit [7:0] ra, rb;
    bit [9:0] ca, cb;
    bit found;
    found = 1'b0;
    for (int t = 0; t < 8 && !found; t++) begin
      if ($urandom_range(99) < 75 && img < NIMG && rows_done[img] > 0) begin
        ra = $urandom_range(rows_done[img] - 1);
        rb = $urandom_range(rows_done[img] - 1);
        ca = $urandom_range(active_cols() - 1);
        cb = $urandom_range(active_cols() - 1);
      end else begin
        ra = $urandom();
        rb = $urandom();
        ca = $urandom();
        cb = $urandom();
      end
      found = !query_in_range(img, ra, rb, ca, cb) ||
              (cell_written[cell_idx(img, ra, ca)] && cell_written[cell_idx(img, ra, cb)] &&
               cell_written[cell_idx(img, rb, ca)] && cell_written[cell_idx(img, rb, cb)]);
    end
    if (!found) img = 2'd3;
    send_word(sar_pkg::CMD_QUERY, img, 24'($urandom()), ra, rb, ca, cb);
  endtask

  task automatic test_directed();
    write_reg(sar_pkg::CFG_COLS, 24'd0);
    write_reg(sar_pkg::CFG_SHIFT, 24'd0);
    write_reg(sar_pkg::CFG_SCALE, 24'd256);
    send_word(sar_pkg::CMD_START, 2'd0);
    send_word(sar_pkg::CMD_LOAD, 2'd0, 24'h7fffff);
    send_word(sar_pkg::CMD_LOAD, 2'd0, 24'h800000);
    send_word(sar_pkg::CMD_LOAD, 2'd0, 24'h000800);
    send_word(sar_pkg::CMD_LOAD, 2'd0, 24'hfff800);
    send_word(sar_pkg::CMD_LOAD, 2'd3, 24'h123456);
    send_word(sar_pkg::CMD_START, 2'd3);
    send_word(sar_pkg::CMD_NONE, 2'd0, 24'hffffff, 8'hff, 8'hff, 10'h3ff, 10'h3ff);
    send_word(sar_pkg::CMD_QUERY, 2'd0, '0, 8'd0, 8'd1, 10'd0, 10'd1);
    send_word(sar_pkg::CMD_QUERY, 2'd0, '0, 8'd1, 8'd0, 10'd0, 10'd1);
    send_word(sar_pkg::CMD_QUERY, 2'd0, '0, 8'd1, 8'd1, 10'd0, 10'd1);
    send_word(sar_pkg::CMD_QUERY, 2'd0, '0, 8'd0, 8'd1, 10'd1, 10'd1);
    send_word(sar_pkg::CMD_QUERY, 2'd0, '0, 8'd0, 8'd2, 10'd0, 10'd1);
    send_word(sar_pkg::CMD_QUERY, 2'd0, '0, 8'd0, 8'd1, 10'd0, 10'd2);
    send_word(sar_pkg::CMD_QUERY, 2'd3, '0, 8'd0, 8'd0, 10'd0, 10'd0);
    send_word(sar_pkg::CMD_QUERY, 2'd1, '0, 8'd0, 8'd0, 10'd0, 10'd0);
    send_word(sar_pkg::CMD_QUERY, 2'd2, '0, 8'hff, 8'hff, 10'h3ff, 10'h3ff);
    // The next image shares the column buffer that image 0 left behind.
    send_word(sar_pkg::CMD_LOAD, 2'd1, 24'h001000);
    send_word(sar_pkg::CMD_LOAD, 2'd1, 24'h002000);
    send_word(sar_pkg::CMD_LOAD, 2'd1, 24'h003000);
    send_word(sar_pkg::CMD_LOAD, 2'd1, 24'h004000);
    send_word(sar_pkg::CMD_QUERY, 2'd1, '0, 8'd1, 8'd0, 10'd1, 10'd0);
  endtask

  task automatic test_short_row();
    write_reg(sar_pkg::CFG_COLS, 24'd8);
    send_word(sar_pkg::CMD_START, 2'd2);
    load_rows(2'd2, 1);
    repeat (5) send_word(sar_pkg::CMD_LOAD, 2'd2, pick_sample());
    // Lowering the width below the open column closes that row on the next sample.
    write_reg(sar_pkg::CFG_COLS, 24'd4);
    repeat (6) send_word(sar_pkg::CMD_LOAD, 2'd2, pick_sample());
    repeat (6) send_query(2'd2);
  endtask

  task automatic test_capacity();
    write_reg(sar_pkg::CFG_COLS, 24'd1);
    write_reg(sar_pkg::CFG_SCALE, 24'hffffff);
    write_reg(sar_pkg::CFG_SHIFT, 24'h800000);
    send_word(sar_pkg::CMD_START, 2'd2);
    load_rows(2'd2, NROWS + 1);
    send_word(sar_pkg::CMD_QUERY, 2'd2, '0, 8'd0, 8'd255, 10'd0, 10'd1);
    send_word(sar_pkg::CMD_QUERY, 2'd2, '0, 8'd255, 8'd0, 10'd1, 10'd0);
    repeat (6) send_query(2'd2);
  endtask

  task automatic test_full_width();
    write_reg(sar_pkg::CFG_COLS, 24'd2047);
    write_reg(sar_pkg::CFG_SHIFT, 24'h7fffff);
    send_word(sar_pkg::CMD_START, 2'd1);
    load_rows(2'd1, 1);
    send_word(sar_pkg::CMD_QUERY, 2'd1, '0, 8'd0, 8'd0, 10'd0, 10'd1023);
    repeat (4) send_query(2'd1);
    write_reg(sar_pkg::CFG_COLS, 24'd1024);
    send_word(sar_pkg::CMD_QUERY, 2'd1, '0, 8'd0, 8'd0, 10'd1023, 10'd0);
  endtask

  task automatic test_random_phase(int unsigned src_pct, int unsigned snk_pct,
                                   int unsigned nwords);
    int unsigned stop_at;
    bit [1:0] img;
    bit paused;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at = words_sent + nwords;
    paused = 1'b0;
    while (words_sent < stop_at) begin
      if ($urandom_range(3) == 0) begin
        write_reg(sar_pkg::CFG_COLS, 24'($urandom_range(2, 12)));
        write_reg(sar_pkg::CFG_SHIFT, 24'($urandom()));
        write_reg(sar_pkg::CFG_SCALE, 24'($urandom()));
      end
      img = $urandom_range(NIMG - 1);
      if ($urandom_range(99) < 80) begin
        send_word(sar_pkg::CMD_START, img);
        load_rows(img, $urandom_range(1, 6));
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 5)) send_word(
          sar_pkg::CMD_LOAD, img, pick_sample());
        repeat ($urandom_range(2, 8)) send_query(img);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(3))
            0: send_word(sar_pkg::CMD_NONE, 2'($urandom()), 24'($urandom()));
            1: send_word(sar_pkg::CMD_LOAD, 2'($urandom()), pick_sample());
            2: send_query(2'($urandom()));
            default: send_word(sar_pkg::CMD_START, 2'd3);
          endcase
        end
      end
      if (!paused && words_sent >= stop_at - nwords / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    cols_reg = 11'd800;
    shift_reg = '0;
    scale_reg = 24'd256;
    row_acc = '0;
    load_col = 0;
    foreach (rows_done[i]) rows_done[i] = 0;
    foreach (col_acc[i]) col_acc[i] = '0;
    src_idle_pct = 18;
    snk_idle_pct = 72;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_short_row();
    test_capacity();
    test_random_phase(18, 72, 30);
    test_random_phase(72, 18, 30);
    test_full_width();
    test_random_phase(0, 0, 30);
    drain();
    $display("Sent %0d words and checked %0d query results, covering range, zero-area,",
             words_sent, answers_checked);
    $display("capacity, full-width and shared-buffer cases under random stalls.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
